FILE: design/dmrk_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Dual motor ramp kickstart package
// Widths, register indexes, reset values and shared types of the duty shaper.
// ----------------------------------------------------------------------------
package dmrk_pkg;

  localparam int unsigned REQ_W      = 13;
  localparam int unsigned DUTY_W     = 12;
  localparam int unsigned RAMP_W     = 8;
  localparam int unsigned MS_W       = 10;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned STEP_W     = MS_W + RAMP_W;
  localparam int unsigned SUM_W      = STEP_W + 2;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 12;

  localparam logic [DUTY_W-1:0] DUTY_BOUND = 12'd4095;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_DUTY_LIMIT      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RAMP_PER_MS     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAP_LIMIT_MS    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAP_FALLBACK_MS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_KICK_WINDOW_MS  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SLOW_THRESHOLD  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_KICK_DUTY       = 3'd6;

  // Reset values of the configuration registers.
  localparam logic [DUTY_W-1:0] DUTY_LIMIT_RST      = 12'd255;
  localparam logic [RAMP_W-1:0] RAMP_PER_MS_RST     = 8'd3;
  localparam logic [MS_W-1:0]   GAP_LIMIT_MS_RST    = 10'd50;
  localparam logic [MS_W-1:0]   GAP_FALLBACK_MS_RST = 10'd5;
  localparam logic [MS_W-1:0]   KICK_WINDOW_MS_RST  = 10'd15;
  localparam logic [DUTY_W-1:0] SLOW_THRESHOLD_RST  = 12'd120;
  localparam logic [DUTY_W-1:0] KICK_DUTY_RST       = 12'd220;

  typedef logic signed [REQ_W-1:0] duty_t;
  typedef logic [DUTY_W-1:0]       mag_t;
  typedef logic [MS_W-1:0]         ms_t;
  typedef logic [TIME_W-1:0]       stamp_t;

  typedef struct packed {
    mag_t              duty_limit;
    logic [RAMP_W-1:0] ramp_per_ms;
    ms_t               gap_limit_ms;
    ms_t               gap_fallback_ms;
    ms_t               kick_window_ms;
    mag_t              slow_threshold;
    mag_t              kick_duty;
  } cfg_t;

  // Item as it leaves the front stage.
  typedef struct packed {
    duty_t left_kick;
    duty_t right_kick;
    duty_t average;
    ms_t   dt;
  } stage_t;

endpackage
`default_nettype wire

FILE: design/dmrk_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Dual motor ramp kickstart channels
// Request channel and result channel, each with valid, ready and payload.
// ----------------------------------------------------------------------------
interface dmrk_in_if import dmrk_pkg::*; ();
  logic   valid;
  logic   ready;
  duty_t  left_request;
  duty_t  right_request;
  stamp_t now_ms;
  stamp_t state_start_ms;

  modport source (output valid, left_request, right_request, now_ms, state_start_ms,
                  input ready);
  modport sink   (input valid, left_request, right_request, now_ms, state_start_ms,
                  output ready);
endinterface

interface dmrk_out_if import dmrk_pkg::*; ();
  logic  valid;
  logic  ready;
  mag_t  left_forward_duty;
  mag_t  left_reverse_duty;
  mag_t  right_forward_duty;
  mag_t  right_reverse_duty;
  duty_t average_drive;

  modport source (output valid, left_forward_duty, left_reverse_duty, right_forward_duty,
                  right_reverse_duty, average_drive, input ready);
  modport sink   (input valid, left_forward_duty, left_reverse_duty, right_forward_duty,
                  right_reverse_duty, average_drive, output ready);
endinterface
`default_nettype wire

FILE: design/dmrk_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Dual motor ramp kickstart configuration registers
// Write-only register file; writes to unused indexes are dropped.
// ----------------------------------------------------------------------------
module dmrk_cfg_regs import dmrk_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  output cfg_t                  cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_DUTY_LIMIT:      cfg_d.duty_limit      = cfg_wdata_i[DUTY_W-1:0];
        REG_RAMP_PER_MS:     cfg_d.ramp_per_ms     = cfg_wdata_i[RAMP_W-1:0];
        REG_GAP_LIMIT_MS:    cfg_d.gap_limit_ms    = cfg_wdata_i[MS_W-1:0];
        REG_GAP_FALLBACK_MS: cfg_d.gap_fallback_ms = cfg_wdata_i[MS_W-1:0];
        REG_KICK_WINDOW_MS:  cfg_d.kick_window_ms  = cfg_wdata_i[MS_W-1:0];
        REG_SLOW_THRESHOLD:  cfg_d.slow_threshold  = cfg_wdata_i[DUTY_W-1:0];
        REG_KICK_DUTY:       cfg_d.kick_duty       = cfg_wdata_i[DUTY_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.duty_limit      <= DUTY_LIMIT_RST;
      cfg_q.ramp_per_ms     <= RAMP_PER_MS_RST;
      cfg_q.gap_limit_ms    <= GAP_LIMIT_MS_RST;
      cfg_q.gap_fallback_ms <= GAP_FALLBACK_MS_RST;
      cfg_q.kick_window_ms  <= KICK_WINDOW_MS_RST;
      cfg_q.slow_threshold  <= SLOW_THRESHOLD_RST;
      cfg_q.kick_duty       <= KICK_DUTY_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

FILE: design/dmrk_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Dual motor ramp kickstart front stage
// Applies the kickstart, forms the average and the effective elapsed time.
// ----------------------------------------------------------------------------
module dmrk_front import dmrk_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  cfg_t           cfg_i,
  dmrk_in_if.sink        req_i,
  output logic           s1_valid_o,
  input  logic           s1_ready_i,
  output stage_t         s1_o
);

  // Inside the kick window, a slow nonzero request is replaced by the kick duty with its own sign.
  function automatic duty_t kick_req(duty_t req, logic active, mag_t thr, mag_t kd);
    logic [REQ_W-1:0] mag;
    duty_t            kicked;
    duty_t            result;
    mag    = req[REQ_W-1] ? $unsigned(-req) : $unsigned(req);
    kicked = req[REQ_W-1] ? -$signed({1'b0, kd}) : $signed({1'b0, kd});
    result = req;
    if (active && (mag != '0) && (mag < {1'b0, thr})) begin
      result = kicked;
    end
    return result;
  endfunction

  logic                  s1_valid_q;
  stage_t                s1_q, s1_d;
  stamp_t                last_q;
  logic                  accept;
  stamp_t                since_start;
  stamp_t                elapsed;
  logic                  kick_active;
  logic signed [REQ_W:0] pair_sum;
  logic signed [REQ_W:0] pair_adj;

  assign req_i.ready = !s1_valid_q || s1_ready_i;
  assign accept      = req_i.valid && req_i.ready;

  always_comb begin
    since_start = req_i.now_ms - req_i.state_start_ms;
    kick_active = since_start < {{(TIME_W-MS_W){1'b0}}, cfg_i.kick_window_ms};

    s1_d.left_kick  = kick_req(req_i.left_request, kick_active,
                               cfg_i.slow_threshold, cfg_i.kick_duty);
    s1_d.right_kick = kick_req(req_i.right_request, kick_active,
                               cfg_i.slow_threshold, cfg_i.kick_duty);

    // Halve toward zero: a negative odd sum is bumped up by one first.
    pair_sum = {s1_d.left_kick[REQ_W-1], s1_d.left_kick}
             + {s1_d.right_kick[REQ_W-1], s1_d.right_kick};
    pair_adj = pair_sum + {{REQ_W{1'b0}}, pair_sum[REQ_W] & pair_sum[0]};
    s1_d.average = pair_adj[REQ_W:1];

    elapsed = req_i.now_ms - last_q;
    if (elapsed > {{(TIME_W-MS_W){1'b0}}, cfg_i.gap_limit_ms}) begin
      s1_d.dt = cfg_i.gap_fallback_ms;
    end else begin
      s1_d.dt = elapsed[MS_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      last_q     <= '0;
    end else begin
      if (req_i.ready) begin
        s1_valid_q <= req_i.valid;
      end
      if (accept) begin
        last_q <= req_i.now_ms;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q <= s1_d;
    end
  end

  assign s1_valid_o = s1_valid_q;
  assign s1_o       = s1_q;

`ifndef SYNTHESIS
  a_dt_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (s1_q.dt <= cfg_i.gap_limit_ms) || (s1_q.dt == cfg_i.gap_fallback_ms))
    else $error("elapsed time escaped the gap limit");
  a_zero_not_kicked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (req_i.left_request == '0) |=> s1_q.left_kick == '0)
    else $error("zero request was kicked");
`endif

endmodule
`default_nettype wire

FILE: design/dmrk_shaper.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Dual motor ramp kickstart duty shaper
// Clamps and slew-limits both duties against the applied state and splits them.
// ----------------------------------------------------------------------------
module dmrk_shaper import dmrk_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  cfg_t           cfg_i,
  input  logic           s1_valid_i,
  output logic           s1_ready_o,
  input  stage_t         s1_i,
  dmrk_out_if.source     res_o
);

  function automatic duty_t clamp_duty(duty_t k, mag_t lim);
    duty_t pos_lim;
    duty_t neg_lim;
    duty_t result;
    pos_lim = $signed({1'b0, lim});
    neg_lim = -pos_lim;
    result  = k;
    if (k > pos_lim) begin
      result = pos_lim;
    end else if (k < neg_lim) begin
      result = neg_lim;
    end
    return result;
  endfunction

  // Only a rise in magnitude from zero or within the same sign is limited.
  function automatic duty_t slew_duty(duty_t target, duty_t cur, logic [STEP_W-1:0] step);
    logic signed [SUM_W-1:0] tgt_w;
    logic signed [SUM_W-1:0] up;
    logic signed [SUM_W-1:0] down;
    duty_t                   result;
    tgt_w  = SUM_W'(target);
    up     = SUM_W'(cur) + $signed({2'b00, step});
    down   = SUM_W'(cur) - $signed({2'b00, step});
    result = target;
    priority if ((target == '0) || ((target > 0) && (cur < 0)) || ((target < 0) && (cur > 0)))
    begin
      result = target;
    end else if ((target > 0) && (target > cur)) begin
      result = (up < tgt_w) ? up[REQ_W-1:0] : target;
    end else if ((target < 0) && (target < cur)) begin
      result = (down > tgt_w) ? down[REQ_W-1:0] : target;
    end else begin
      result = target;
    end
    return result;
  endfunction

  logic              out_valid_q;
  logic              advance;
  logic [STEP_W-1:0] step;
  mag_t              lim;
  duty_t             left_applied_q, right_applied_q;
  duty_t             left_d, right_d;
  duty_t             left_neg, right_neg;
  mag_t              lfwd_q, lrev_q, rfwd_q, rrev_q;
  duty_t             avg_q;

  assign s1_ready_o = !out_valid_q || res_o.ready;
  assign advance    = s1_valid_i && s1_ready_o;

  always_comb begin
    step      = STEP_W'(s1_i.dt) * STEP_W'(cfg_i.ramp_per_ms);
    lim       = (cfg_i.duty_limit > DUTY_BOUND) ? DUTY_BOUND : cfg_i.duty_limit;
    left_d    = slew_duty(clamp_duty(s1_i.left_kick, lim), left_applied_q, step);
    right_d   = slew_duty(clamp_duty(s1_i.right_kick, lim), right_applied_q, step);
    left_neg  = -left_d;
    right_neg = -right_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q     <= 1'b0;
      left_applied_q  <= '0;
      right_applied_q <= '0;
    end else begin
      if (s1_ready_o) begin
        out_valid_q <= s1_valid_i;
      end
      if (advance) begin
        left_applied_q  <= left_d;
        right_applied_q <= right_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      lfwd_q <= (left_d > 0) ? left_d[DUTY_W-1:0] : '0;
      lrev_q <= (left_d < 0) ? left_neg[DUTY_W-1:0] : '0;
      rfwd_q <= (right_d > 0) ? right_d[DUTY_W-1:0] : '0;
      rrev_q <= (right_d < 0) ? right_neg[DUTY_W-1:0] : '0;
      avg_q  <= s1_i.average;
    end
  end

  assign res_o.valid              = out_valid_q;
  assign res_o.left_forward_duty  = lfwd_q;
  assign res_o.left_reverse_duty  = lrev_q;
  assign res_o.right_forward_duty = rfwd_q;
  assign res_o.right_reverse_duty = rrev_q;
  assign res_o.average_drive      = avg_q;

`ifndef SYNTHESIS
  a_split_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !((lfwd_q != '0) && (lrev_q != '0)) && !((rfwd_q != '0) && (rrev_q != '0)))
    else $error("forward and reverse duty both driven");
  a_ramp_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && (left_d > 0) && (left_applied_q >= 0)
    |-> (SUM_W'(left_d) - SUM_W'(left_applied_q)) <= $signed({2'b00, step}))
    else $error("left duty rose faster than the ramp allows");
  a_state_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(left_applied_q) && $stable(right_applied_q))
    else $error("applied duty changed without a transfer");
`endif

endmodule
`default_nettype wire

FILE: design/dual_motor_ramp_kickstart.sv
// A request transfer is registered in the front stage; its result is then
// registered in the shaper stage, offered from there and held until it transfers.
// Throughput: one request per cycle while the result side is ready; the front
// and result registers form a two-deep pipeline; applied duty feeds the next item.
// Reset (rst_ni low, asynchronous): pipeline empty, applied duties and the last
// timestamp cleared to zero, configuration registers at their default values.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Dual motor ramp kickstart
// Kickstart, averaging, clamp and upward slew limiting for two PWM motors.
// ----------------------------------------------------------------------------
module dual_motor_ramp_kickstart import dmrk_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  dmrk_in_if.sink               req_i,
  dmrk_out_if.source            res_o
);

  // The front stage takes a request transfer, decides whether the kick window
  // is open, kicks slow requests, averages the kicked pair and converts the time
  // since the previous request into the effective elapsed milliseconds. The
  // last timestamp is tracked at request transfer, so it follows item order.
  //
  // The shaper stage multiplies the elapsed time by the ramp rate, clamps each
  // kicked duty to the duty limit and, unless it reverses sign or is zero, lets its
  // magnitude rise by at most that step over the previously applied duty. It then
  // splits each duty into forward and reverse magnitudes, held until transfer.
  // Either stage keeps accepting while the stage behind it can drain.

  cfg_t   cfg;
  logic   s1_valid;
  logic   s1_ready;
  stage_t s1;

  dmrk_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  dmrk_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .req_i      (req_i),
    .s1_valid_o (s1_valid),
    .s1_ready_i (s1_ready),
    .s1_o       (s1)
  );

  dmrk_shaper u_shaper (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .s1_valid_i (s1_valid),
    .s1_ready_o (s1_ready),
    .s1_i       (s1),
    .res_o      (res_o)
  );

endmodule
`default_nettype wire
